// File: rtl/slc_pkg.sv
// ----------------------------------------------------------------------------
// slc_pkg
// Shared types and constants for the sight line occlusion clip block.
// ----------------------------------------------------------------------------
package slc_pkg;

  localparam int COORD_W   = 16;
  localparam int DIFF_W    = 17;
  localparam int PROD_W    = 34;
  localparam int SUM_W     = 35;
  localparam int DEN_W     = 36;
  localparam int HGT_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int SLOPE_NUM_W = 39;
  localparam int SLOPE_SHIFT = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X   = 3'd0,
    REG_START_Y   = 3'd1,
    REG_END_X     = 3'd2,
    REG_END_Y     = 3'd3,
    REG_EYE       = 3'd4,
    REG_TOP_START = 3'd5,
    REG_BOT_START = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    RES_NONE  = 2'd0,
    RES_PASS  = 2'd1,
    RES_BLOCK = 2'd2
  } wall_res_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_MUL_B,
    CMD_MUL_A,
    CMD_MUL_S1,
    CMD_MUL_S2,
    CMD_SUM,
    CMD_DIV_FRAC,
    CMD_FRAC,
    CMD_DIV_BOT,
    CMD_UPD_BOT,
    CMD_DIV_TOP,
    CMD_UPD_TOP,
    CMD_BEGIN,
    CMD_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t    op;
    wall_res_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic sides_differ;
    logic div_zero;
    logic frac_ok;
    logic two_sided;
    logic flat;
    logic closed;
    logic floor_diff;
    logic ceil_diff;
    logic slopes_meet;
    logic div_done;
  } dp_status_t;

endpackage

// File: rtl/slc_div.sv
// ----------------------------------------------------------------------------
// slc_div
// Restoring signed divider, one quotient bit per cycle, truncates to zero.
// ----------------------------------------------------------------------------
module slc_div #(
  parameter int NUM_W = 51,
  parameter int DEN_W = 36
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DEN_W-1:0] den,
  output logic signed [NUM_W:0]   quot,
  output logic                    done
);
  localparam int CNT_W = $clog2(NUM_W);

  logic [DEN_W-1:0] rem_r, den_r;
  logic [NUM_W-1:0] quo_r;
  logic             neg_r, busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;

  logic [NUM_W-1:0] num_mag;
  logic [DEN_W-1:0] den_mag;
  logic [DEN_W:0]   rs, diff;
  logic             ge;

  assign num_mag = num[NUM_W-1] ? -num : num;
  assign den_mag = den[DEN_W-1] ? -den : den;
  assign rs      = {rem_r, quo_r[NUM_W-1]};
  assign diff    = rs - {1'b0, den_r};
  assign ge      = rs >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(NUM_W - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num_mag;
      den_r <= den_mag;
      neg_r <= num[NUM_W-1] ^ den[DEN_W-1];
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : rs[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign quot = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  assign done = done_r;

endmodule

// File: rtl/slc_dp.sv
// ----------------------------------------------------------------------------
// slc_dp
// Datapath: configuration, wall geometry, shared divider, slope state, output.
// ----------------------------------------------------------------------------
module slc_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  slc_pkg::dp_cmd_t                     cmd,
  output slc_pkg::dp_status_t                  status,
  input  logic                                 cfg_we,
  input  logic [slc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [slc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic signed [slc_pkg::COORD_W-1:0]   in_wall_ax,
  input  logic signed [slc_pkg::COORD_W-1:0]   in_wall_ay,
  input  logic signed [slc_pkg::COORD_W-1:0]   in_wall_bx,
  input  logic signed [slc_pkg::COORD_W-1:0]   in_wall_by,
  input  logic                                 in_two_sided,
  input  logic signed [slc_pkg::HGT_W-1:0]     in_front_floor,
  input  logic signed [slc_pkg::HGT_W-1:0]     in_front_ceiling,
  input  logic signed [slc_pkg::HGT_W-1:0]     in_back_floor,
  input  logic signed [slc_pkg::HGT_W-1:0]     in_back_ceiling,
  output logic [1:0]                           out_wall_status,
  output logic                                 out_trace_blocked,
  output logic signed [slc_pkg::HGT_W-1:0]     out_upper_slope,
  output logic signed [slc_pkg::HGT_W-1:0]     out_lower_slope
);
  import slc_pkg::*;

  localparam int NUM_W = SUM_W + FRAC_BITS;
  localparam int Q_W   = FRAC_BITS - 1;
  localparam int WIDE_W = NUM_W + 1 + FRAC_BITS;
  localparam logic [NUM_W:0] FRAC_ONE = (NUM_W+1)'(1) << FRAC_BITS;
  localparam logic [NUM_W:0] FRAC_MIN = (NUM_W+1)'(4);

  // configuration
  logic signed [COORD_W-1:0] sx_r, sy_r, ex_r, ey_r;
  logic signed [HGT_W-1:0]   eye_r, top_start_r, bot_start_r;
  // trace state and outputs
  logic signed [HGT_W-1:0]   top_r, bot_r;
  logic                      blocked_r;
  wall_res_t                 status_r;
  logic                      out_blocked_r;
  logic signed [HGT_W-1:0]   out_upper_r, out_lower_r;
  // per-wall payload
  logic signed [DIFF_W-1:0]  ddx_r, ddy_r, exb_r, eyb_r, exa_r, eya_r;
  logic signed [DIFF_W-1:0]  nx_r, ny_r, ecx_r, ecy_r;
  logic                      two_sided_r;
  logic signed [HGT_W-1:0]   ff_r, fc_r, bf_r, bc_r;
  logic signed [PROD_W-1:0]  p0_r, p1_r;
  logic                      sb_r, sa_r;
  logic signed [SUM_W-1:0]   s1_r;
  logic signed [DEN_W-1:0]   div_r;
  logic signed [NUM_W:0]     frac_r;

  logic signed [HGT_W-1:0]   top_h, bot_h, sel_h;
  logic signed [HGT_W:0]     h_diff;
  logic signed [SLOPE_NUM_W-1:0] h_scaled;
  logic signed [NUM_W-1:0]   div_num;
  logic signed [DEN_W-1:0]   div_den;
  logic                      div_start, div_done;
  logic signed [NUM_W:0]     div_q;
  logic signed [WIDE_W-1:0]  wide;
  logic signed [HGT_W-1:0]   slope_sat;
  logic [Q_W-1:0]            q;

  assign top_h  = (fc_r < bc_r) ? fc_r : bc_r;
  assign bot_h  = (ff_r > bf_r) ? ff_r : bf_r;
  assign sel_h  = (cmd.op == CMD_DIV_TOP) ? top_h : bot_h;
  assign h_diff = {sel_h[HGT_W-1], sel_h} - {eye_r[HGT_W-1], eye_r};
  assign h_scaled = {h_diff, {SLOPE_SHIFT{1'b0}}};
  assign q      = frac_r[FRAC_BITS:2];

  always_comb begin
    div_start = 1'b0;
    div_num   = {{(NUM_W-SLOPE_NUM_W){h_scaled[SLOPE_NUM_W-1]}}, h_scaled};
    div_den   = {{(DEN_W-Q_W){1'b0}}, q};
    case (cmd.op)
      CMD_DIV_FRAC: begin
        div_start = 1'b1;
        div_num   = {s1_r, {FRAC_BITS{1'b0}}};
        div_den   = div_r;
      end
      CMD_DIV_BOT, CMD_DIV_TOP: div_start = 1'b1;
      default: div_start = 1'b0;
    endcase
  end

  slc_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (div_q),
    .done  (div_done)
  );

  // scale the quotient back to the slope format and clamp to 32 bits
  assign wide = {{FRAC_BITS{div_q[NUM_W]}}, div_q} <<< (FRAC_BITS - 8);
  always_comb begin
    if (wide > $signed({{(WIDE_W-31){1'b0}}, {31{1'b1}}})) begin
      slope_sat = {1'b0, {31{1'b1}}};
    end else if (wide < $signed({{(WIDE_W-31){1'b1}}, {31{1'b0}}})) begin
      slope_sat = {1'b1, {31{1'b0}}};
    end else begin
      slope_sat = wide[HGT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r          <= '0;
      sy_r          <= '0;
      ex_r          <= '0;
      ey_r          <= '0;
      eye_r         <= '0;
      top_start_r   <= '0;
      bot_start_r   <= '0;
      top_r         <= '0;
      bot_r         <= '0;
      blocked_r     <= 1'b0;
      status_r      <= RES_NONE;
      out_blocked_r <= 1'b0;
      out_upper_r   <= '0;
      out_lower_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START_X:   sx_r        <= cfg_wdata[COORD_W-1:0];
          REG_START_Y:   sy_r        <= cfg_wdata[COORD_W-1:0];
          REG_END_X:     ex_r        <= cfg_wdata[COORD_W-1:0];
          REG_END_Y:     ey_r        <= cfg_wdata[COORD_W-1:0];
          REG_EYE:       eye_r       <= cfg_wdata[HGT_W-1:0];
          REG_TOP_START: top_start_r <= cfg_wdata[HGT_W-1:0];
          REG_BOT_START: bot_start_r <= cfg_wdata[HGT_W-1:0];
          default: ;
        endcase
      end
      case (cmd.op)
        CMD_UPD_BOT: if (slope_sat > bot_r) bot_r <= slope_sat;
        CMD_UPD_TOP: if (slope_sat < top_r) top_r <= slope_sat;
        CMD_BEGIN: begin
          top_r         <= top_start_r;
          bot_r         <= bot_start_r;
          blocked_r     <= 1'b0;
          status_r      <= RES_NONE;
          out_blocked_r <= 1'b0;
          out_upper_r   <= top_start_r;
          out_lower_r   <= bot_start_r;
        end
        CMD_RESULT: begin
          status_r      <= cmd.code;
          blocked_r     <= blocked_r | (cmd.code == RES_BLOCK);
          out_blocked_r <= blocked_r | (cmd.code == RES_BLOCK);
          out_upper_r   <= top_r;
          out_lower_r   <= bot_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_LOAD: begin
        ddx_r       <= {ex_r[COORD_W-1], ex_r} - {sx_r[COORD_W-1], sx_r};
        ddy_r       <= {ey_r[COORD_W-1], ey_r} - {sy_r[COORD_W-1], sy_r};
        exb_r       <= {in_wall_bx[COORD_W-1], in_wall_bx} - {sx_r[COORD_W-1], sx_r};
        eyb_r       <= {in_wall_by[COORD_W-1], in_wall_by} - {sy_r[COORD_W-1], sy_r};
        exa_r       <= {in_wall_ax[COORD_W-1], in_wall_ax} - {sx_r[COORD_W-1], sx_r};
        eya_r       <= {in_wall_ay[COORD_W-1], in_wall_ay} - {sy_r[COORD_W-1], sy_r};
        nx_r        <= {in_wall_ay[COORD_W-1], in_wall_ay} - {in_wall_by[COORD_W-1], in_wall_by};
        ny_r        <= {in_wall_bx[COORD_W-1], in_wall_bx} - {in_wall_ax[COORD_W-1], in_wall_ax};
        ecx_r       <= {ex_r[COORD_W-1], ex_r} - {in_wall_ax[COORD_W-1], in_wall_ax};
        ecy_r       <= {ey_r[COORD_W-1], ey_r} - {in_wall_ay[COORD_W-1], in_wall_ay};
        two_sided_r <= in_two_sided;
        ff_r        <= in_front_floor;
        fc_r        <= in_front_ceiling;
        bf_r        <= in_back_floor;
        bc_r        <= in_back_ceiling;
      end
      CMD_MUL_B: begin
        p0_r <= ddy_r * exb_r;
        p1_r <= eyb_r * ddx_r;
      end
      CMD_MUL_A: begin
        sb_r <= p0_r < p1_r;
        p0_r <= ddy_r * exa_r;
        p1_r <= eya_r * ddx_r;
      end
      CMD_MUL_S1: begin
        sa_r <= p0_r < p1_r;
        p0_r <= nx_r * exa_r;
        p1_r <= ny_r * eya_r;
      end
      CMD_MUL_S2: begin
        s1_r <= {p0_r[PROD_W-1], p0_r} + {p1_r[PROD_W-1], p1_r};
        p0_r <= nx_r * ecx_r;
        p1_r <= ny_r * ecy_r;
      end
      CMD_SUM: div_r <= {s1_r[SUM_W-1], s1_r}
                        + {{2{p0_r[PROD_W-1]}}, p0_r} + {{2{p1_r[PROD_W-1]}}, p1_r};
      CMD_FRAC: frac_r <= div_q;
      default: ;
    endcase
  end

  always_comb begin
    status.sides_differ = sb_r != sa_r;
    status.div_zero     = div_r == '0;
    status.frac_ok      = !frac_r[NUM_W] && (frac_r >= FRAC_MIN) && (frac_r <= FRAC_ONE);
    status.two_sided    = two_sided_r;
    status.flat         = (ff_r == bf_r) && (fc_r == bc_r);
    status.closed       = bot_h >= top_h;
    status.floor_diff   = ff_r != bf_r;
    status.ceil_diff    = fc_r != bc_r;
    status.slopes_meet  = top_r <= bot_r;
    status.div_done     = div_done;
  end

  assign out_wall_status   = status_r;
  assign out_trace_blocked = out_blocked_r;
  assign out_upper_slope   = out_upper_r;
  assign out_lower_slope   = out_lower_r;

endmodule

// File: rtl/slc_ctrl.sv
// ----------------------------------------------------------------------------
// slc_ctrl
// Sequencer: steps one item through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
module slc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_op,
  output logic                out_valid,
  input  logic                out_ready,
  output slc_pkg::dp_cmd_t    cmd,
  input  slc_pkg::dp_status_t status
);
  import slc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MB, S_MA, S_MS1, S_MS2, S_SUM, S_DFRAC, S_WFRAC,
    S_CHK, S_DBOT, S_WBOT, S_DTOP, S_WTOP, S_FIN, S_RESP
  } state_t;

  state_t    state_r, state_nxt;
  wall_res_t code_r, code_nxt;
  logic      begin_r, begin_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      resp_fire;

  assign resp_fire = (state_r == S_RESP) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    code_nxt      = code_r;
    begin_nxt     = begin_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = CMD_NONE;
    cmd.code      = code_r;
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.op    = CMD_LOAD;
        begin_nxt = !in_op;
        code_nxt  = RES_NONE;
        state_nxt = in_op ? S_MB : S_RESP;
      end
      S_MB:  begin cmd.op = CMD_MUL_B;  state_nxt = S_MA;  end
      S_MA:  begin cmd.op = CMD_MUL_A;  state_nxt = S_MS1; end
      S_MS1: begin cmd.op = CMD_MUL_S1; state_nxt = S_MS2; end
      S_MS2: begin cmd.op = CMD_MUL_S2; state_nxt = S_SUM; end
      S_SUM: begin
        cmd.op    = CMD_SUM;
        state_nxt = status.sides_differ ? S_DFRAC : S_RESP;
      end
      S_DFRAC: begin
        if (status.div_zero) begin
          state_nxt = S_RESP;
        end else begin
          cmd.op    = CMD_DIV_FRAC;
          state_nxt = S_WFRAC;
        end
      end
      S_WFRAC: if (status.div_done) begin
        cmd.op    = CMD_FRAC;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (!status.frac_ok) begin
          state_nxt = S_RESP;
        end else if (!status.two_sided || (!status.flat && status.closed)) begin
          code_nxt  = RES_BLOCK;
          state_nxt = S_RESP;
        end else if (status.flat) begin
          code_nxt  = RES_PASS;
          state_nxt = S_RESP;
        end else if (status.floor_diff) begin
          state_nxt = S_DBOT;
        end else begin
          state_nxt = S_DTOP;
        end
      end
      S_DBOT: begin cmd.op = CMD_DIV_BOT; state_nxt = S_WBOT; end
      S_WBOT: if (status.div_done) begin
        cmd.op    = CMD_UPD_BOT;
        state_nxt = status.ceil_diff ? S_DTOP : S_FIN;
      end
      S_DTOP: begin cmd.op = CMD_DIV_TOP; state_nxt = S_WTOP; end
      S_WTOP: if (status.div_done) begin
        cmd.op    = CMD_UPD_TOP;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        code_nxt  = status.slopes_meet ? RES_BLOCK : RES_PASS;
        state_nxt = S_RESP;
      end
      S_RESP: if (resp_fire) begin
        cmd.op        = begin_r ? CMD_BEGIN : CMD_RESULT;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      code_r      <= RES_NONE;
      begin_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      code_r      <= code_nxt;
      begin_r     <= begin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("accepted beat did not start a sequence");
  a_resp_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    resp_fire |=> out_valid_r)
    else $error("result issued without out_valid");
  a_div_wait_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WFRAC && status.div_done) |=> (state_r == S_CHK))
    else $error("fraction ready but sequencer stalled");
  a_begin_short: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_op) |=> (state_r == S_RESP))
    else $error("begin beat did not go straight to response");

endmodule

// File: rtl/sight_line_occlusion_clip_core.sv
// ----------------------------------------------------------------------------
// sight_line_occlusion_clip_core
// Line-of-sight trace clipped against a stream of walls, one result per beat.
// ----------------------------------------------------------------------------
// One item at a time. A begin beat goes from idle straight to the response
// state. A wall beat that misses the trace passes through the load, multiply
// and sum states. A wall whose ends straddle the trace adds the fraction
// division and a check state. Each division has an issue state, then
// FRAC_BITS+35 quotient bits, then a state that picks up the quotient. When
// the floors or ceilings differ, the wall adds one more division for each
// and a final state to compare the slopes. Most of a wall's time goes to the
// shared one-bit-per-cycle divider. in_ready is high only while the
// sequencer is idle. A finished result sits in the output register, and
// the next beat is taken meanwhile. A result that is still waiting holds the
// sequencer in its response state until out_ready. Configuration writes land
// at once and are expected only while the block is idle.
// ----------------------------------------------------------------------------
module sight_line_occlusion_clip_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [slc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [slc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_op,
  input  logic signed [slc_pkg::COORD_W-1:0]   in_wall_ax,
  input  logic signed [slc_pkg::COORD_W-1:0]   in_wall_ay,
  input  logic signed [slc_pkg::COORD_W-1:0]   in_wall_bx,
  input  logic signed [slc_pkg::COORD_W-1:0]   in_wall_by,
  input  logic                                 in_two_sided,
  input  logic signed [slc_pkg::HGT_W-1:0]     in_front_floor,
  input  logic signed [slc_pkg::HGT_W-1:0]     in_front_ceiling,
  input  logic signed [slc_pkg::HGT_W-1:0]     in_back_floor,
  input  logic signed [slc_pkg::HGT_W-1:0]     in_back_ceiling,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_wall_status,
  output logic                                 out_trace_blocked,
  output logic signed [slc_pkg::HGT_W-1:0]     out_upper_slope,
  output logic signed [slc_pkg::HGT_W-1:0]     out_lower_slope
);
  import slc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: walks wall beats through geometry, division and slope update
  slc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // datapath: config registers, exact products, divider, slope state
  slc_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_wall_ax        (in_wall_ax),
    .in_wall_ay        (in_wall_ay),
    .in_wall_bx        (in_wall_bx),
    .in_wall_by        (in_wall_by),
    .in_two_sided      (in_two_sided),
    .in_front_floor    (in_front_floor),
    .in_front_ceiling  (in_front_ceiling),
    .in_back_floor     (in_back_floor),
    .in_back_ceiling   (in_back_ceiling),
    .out_wall_status   (out_wall_status),
    .out_trace_blocked (out_trace_blocked),
    .out_upper_slope   (out_upper_slope),
    .out_lower_slope   (out_lower_slope)
  );

endmodule

// File: test/sight_line_occlusion_clip_core_tb.sv
// ----------------------------------------------------------------------------
// sight_line_occlusion_clip_core_tb
// Randomized trace checks against a behavioral sight-line predictor.
// ----------------------------------------------------------------------------
// Drives begin and wall beats through the valid/ready input channel, predicts
// the wall status, sticky blocked flag and clipped slopes for each accepted
// beat, and compares them field by field with the result channel. The trace
// geometry and slope registers are rewritten between phases while idle.
// ----------------------------------------------------------------------------
module sight_line_occlusion_clip_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import slc_pkg::*;

  localparam int FRAC = 16;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    logic             op;
    logic signed [15:0] ax, ay, bx, by;
    logic             two_sided;
    logic signed [31:0] ff, fc, bf, bc;
  } wall_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               blocked;
    logic signed [31:0] upper;
    logic signed [31:0] lower;
  } sight_res_t;

  // --------------------------------------------------------------------------
  // Scoreboard: holds the trace setup, the slope state and the queue of
  // expected results.
  // --------------------------------------------------------------------------
  class sight_scoreboard;
    longint sx0, sy0, ex0, ey0, eye, top_init, bot_init;
    longint top_sl, bot_sl;
    bit     blk;
    sight_res_t pending[$];
    int     errors;

    function void clear();
      sx0 = 0; sy0 = 0; ex0 = 0; ey0 = 0; eye = 0; top_init = 0; bot_init = 0;
      top_sl = 0; bot_sl = 0; blk = 0; errors = 0;
    endfunction

    function void set_reg(cfg_reg_t r, logic [31:0] v);
      case (r)
        REG_START_X:   sx0 = $signed(v[15:0]);
        REG_START_Y:   sy0 = $signed(v[15:0]);
        REG_END_X:     ex0 = $signed(v[15:0]);
        REG_END_Y:     ey0 = $signed(v[15:0]);
        REG_EYE:       eye = $signed(v);
        REG_TOP_START: top_init = $signed(v);
        REG_BOT_START: bot_init = $signed(v);
        default: ;
      endcase
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint height_slope(longint h, longint q);
      longint t;
      t = ((h - eye) * 64) / q;
      return clip32(t * (64'sd1 <<< (FRAC - 8)));
    endfunction

    function wall_res_t judge_wall(wall_beat_t w);
      longint ax, ay, bx, by, ddx, ddy, ex, ey, nx, ny, s1, s2, dv, frac;
      longint top, bot, q, s;
      bit sa, sb;
      ax = w.ax; ay = w.ay; bx = w.bx; by = w.by;
      ddx = ex0 - sx0; ddy = ey0 - sy0;
      ex = bx - sx0; ey = by - sy0;
      sb = (ddy * ex) < (ey * ddx);
      ex = ax - sx0; ey = ay - sy0;
      sa = (ddy * ex) < (ey * ddx);
      if (sa == sb) return RES_NONE;
      nx = ay - by; ny = bx - ax;
      s1 = nx * ex + ny * ey;
      s2 = nx * (ex0 - ax) + ny * (ey0 - ay);
      dv = s1 + s2;
      if (dv == 0) return RES_NONE;
      frac = (s1 * (64'sd1 <<< FRAC)) / dv;
      if (frac < 4 || frac > (64'sd1 <<< FRAC)) return RES_NONE;
      if (!w.two_sided) return RES_BLOCK;
      if (w.ff == w.bf && w.fc == w.bc) return RES_PASS;
      top = (w.fc < w.bc) ? longint'(w.fc) : longint'(w.bc);
      bot = (w.ff > w.bf) ? longint'(w.ff) : longint'(w.bf);
      if (bot >= top) return RES_BLOCK;
      q = frac >>> 2;
      if (w.ff != w.bf) begin
        s = height_slope(bot, q);
        if (s > bot_sl) bot_sl = s;
      end
      if (w.fc != w.bc) begin
        s = height_slope(top, q);
        if (s < top_sl) top_sl = s;
      end
      return (top_sl <= bot_sl) ? RES_BLOCK : RES_PASS;
    endfunction

    function void note_beat(wall_beat_t w);
      sight_res_t r;
      wall_res_t st;
      st = RES_NONE;
      if (!w.op) begin
        top_sl = top_init; bot_sl = bot_init; blk = 0;
      end else begin
        st = judge_wall(w);
        if (st == RES_BLOCK) blk = 1;
      end
      r.status = st; r.blocked = blk;
      r.upper = top_sl[31:0]; r.lower = bot_sl[31:0];
      pending.push_back(r);
    endfunction

    function int check_result(sight_res_t got, output string msg);
      sight_res_t exp_r;
      if (pending.size() == 0) begin
        msg = "result beat with nothing expected";
        return 1;
      end
      exp_r = pending.pop_front();
      msg = "";
      if (got.status != exp_r.status)
        msg = $sformatf("%s status %0d/%0d", msg, got.status, exp_r.status);
      if (got.blocked != exp_r.blocked)
        msg = $sformatf("%s blocked %0d/%0d", msg, got.blocked, exp_r.blocked);
      if (got.upper != exp_r.upper)
        msg = $sformatf("%s upper %0d/%0d", msg, got.upper, exp_r.upper);
      if (got.lower != exp_r.lower)
        msg = $sformatf("%s lower %0d/%0d", msg, got.lower, exp_r.lower);
      return (msg != "");
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 0;
  logic in_ready;
  wall_beat_t in_beat = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] out_wall_status;
  logic out_trace_blocked;
  logic signed [31:0] out_upper_slope, out_lower_slope;

  sight_scoreboard sb;
  int idle_cycles = 0;
  int fail_count = 0;

  always #5 clk = ~clk;

  sight_line_occlusion_clip_core #(.FRAC_BITS(FRAC)) i_dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_op(in_beat.op),
    .in_wall_ax(in_beat.ax), .in_wall_ay(in_beat.ay),
    .in_wall_bx(in_beat.bx), .in_wall_by(in_beat.by),
    .in_two_sided(in_beat.two_sided),
    .in_front_floor(in_beat.ff), .in_front_ceiling(in_beat.fc),
    .in_back_floor(in_beat.bf), .in_back_ceiling(in_beat.bc),
    .out_valid, .out_ready, .out_wall_status, .out_trace_blocked,
    .out_upper_slope, .out_lower_slope
  );

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t:%s", $realtime, msg);
    fail_count++;
  endtask

  // Sample both channels at the rising edge; note inputs before results so a
  // same-edge pass-through would still find its expectation.
  always @(posedge clk) begin
    sight_res_t got;
    string msg;
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_beat(in_beat);
      if (out_valid && out_ready) begin
        got.status = out_wall_status; got.blocked = out_trace_blocked;
        got.upper = out_upper_slope; got.lower = out_lower_slope;
        if (sb.check_result(got, msg)) report_mismatch(msg);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: no beat on either channel for too long ends the run.
  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: before each result, sometimes hold ready low for a random gap.
  initial begin
    int gap;
    int mode;
    forever begin
      @(negedge clk);
      mode = $urandom_range(0, 3);
      gap = (mode == 0) ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  task automatic write_reg(cfg_reg_t r, logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= r; cfg_wdata <= v;
    sb.set_reg(r, v);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // Hold off until every expected result has come, then let the core settle.
  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_beat(wall_beat_t w, bit allow_gap);
    int gap;
    gap = allow_gap ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    repeat (gap) @(negedge clk);
    in_beat <= w; in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid <= 0;
  endtask

  function automatic logic [31:0] rand_height(int span);
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom();
      default: return $signed($urandom_range(0, 2 * span)) - span;
    endcase
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom());
      default: return 16'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  // Walls mostly straddle the trace so crossings and slope clipping happen.
  function automatic wall_beat_t crossing_wall();
    wall_beat_t w;
    longint mx, my, dx, dy, t;
    w = '0;
    w.op = 1;
    if ($urandom_range(0, 5) == 0) begin
      w.ax = rand_coord(); w.ay = rand_coord();
      w.bx = rand_coord(); w.by = rand_coord();
    end else begin
      t = $urandom_range(0, 100);
      mx = sb.sx0 + ((sb.ex0 - sb.sx0) * t) / 100;
      my = sb.sy0 + ((sb.ey0 - sb.sy0) * t) / 100;
      dx = $signed($urandom_range(0, 120)) - 60;
      dy = $signed($urandom_range(0, 120)) - 60;
      w.ax = 16'(mx + dx); w.ay = 16'(my + dy);
      w.bx = 16'(mx - dx); w.by = 16'(my - dy);
    end
    w.two_sided = ($urandom_range(0, 7) != 0);
    w.ff = rand_height(32'h0040_0000);
    w.fc = rand_height(32'h0040_0000);
    w.bf = ($urandom_range(0, 2) == 0) ? w.ff : rand_height(32'h0040_0000);
    w.bc = ($urandom_range(0, 2) == 0) ? w.fc : rand_height(32'h0040_0000);
    if ($urandom_range(0, 3) == 0) begin
      // Keep the opening open: floors below ceilings.
      w.ff = -($urandom_range(0, 32'h0100_0000)); w.bf = -($urandom_range(0, 32'h0100_0000));
      w.fc = $urandom_range(1, 32'h0100_0000); w.bc = $urandom_range(1, 32'h0100_0000);
    end
    return w;
  endfunction

  // Program a trace setting; geometry and slope registers all in one pass.
  task automatic set_trace(logic [15:0] x0, y0, x1, y1, logic [31:0] e, t, b);
    write_reg(REG_START_X, {16'h0000, x0});
    write_reg(REG_START_Y, {16'h0000, y0});
    write_reg(REG_END_X, {16'h0000, x1});
    write_reg(REG_END_Y, {16'h0000, y1});
    write_reg(REG_EYE, e);
    write_reg(REG_TOP_START, t);
    write_reg(REG_BOT_START, b);
  endtask

  initial begin
    wall_beat_t w;
    sb = new();
    sb.clear();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed: begin, crossing walls of each kind, degenerate walls.
    set_trace(16'd0, 16'd0, 16'd1000, 16'd0, 32'd0, 32'h0010_0000, 32'hFFF0_0000);
    w = '0; send_beat(w, 0);                                  // begin
    w = '1; w.op = 0; send_beat(w, 0);                        // begin ignores fields
    w = '0; w.op = 1; w.ax = 100; w.ay = -50; w.bx = 100; w.by = 50;
    w.two_sided = 1; send_beat(w, 0);                         // flat opening passes
    w.fc = 32'h0002_0000; w.bc = 32'h0001_0000; w.ff = 0; w.bf = 32'h0000_8000;
    send_beat(w, 0);                                          // both slopes clip
    w.ax = 500; w.bx = 500; w.ff = 32'h0003_0000; w.bf = 32'h0003_0000;
    send_beat(w, 0);                                          // closed opening
    w.ax = 0; w.bx = 0; w.ay = 1; w.by = -1; send_beat(w, 0); // frac below minimum
    w.ax = 200; w.ay = 5; w.bx = 300; w.by = 5; send_beat(w, 0); // no crossing
    w.ax = 200; w.ay = 0; w.bx = 200; w.by = 0; send_beat(w, 0); // point wall
    w.ax = 700; w.ay = -10; w.bx = 700; w.by = 10; w.two_sided = 0;
    send_beat(w, 0);                                          // one-sided blocks
    w.two_sided = 1; w.ff = 0; w.bf = 0; w.fc = 32'h7FFF_FFFF; w.bc = 32'h8000_0001;
    send_beat(w, 0);                                          // extreme heights
    w.ax = 16'h8000; w.ay = 16'h8000; w.bx = 16'h7FFF; w.by = 16'h7FFF;
    send_beat(w, 0);
    w = '0; send_beat(w, 0);
    wait_drained();

    // Degenerate zero-length trace: every divisor collapses.
    set_trace(16'd5, 16'd5, 16'd5, 16'd5, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    w = '0; send_beat(w, 0);
    w = '0; w.op = 1; w.ax = 0; w.ay = 10; w.bx = 10; w.by = 0; w.two_sided = 1;
    w.ff = 1; send_beat(w, 0);
    wait_drained();

    // Random phases, each programming a trace setting; extremes included.
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: set_trace(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        1: set_trace(16'h7FFF, 16'h0000, 16'h8000, 16'h0000,
                     32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        default: set_trace(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                           $urandom_range(0, 32'h0080_0000),
                           $urandom_range(32'h0001_0000, 32'h0100_0000),
                           -($urandom_range(32'h0001_0000, 32'h0100_0000)));
      endcase
      for (int n = 0; n < 100; n++) begin
        if (n == 0 || $urandom_range(0, 11) == 0) begin
          w = '0;
          w.ax = 16'($urandom()); w.ff = $urandom();
          send_beat(w, 1);
        end else begin
          send_beat(crossing_wall(), $urandom_range(0, 3) != 0);
        end
        if (n == 50) wait_drained();
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
